// ===== hw/rtl/obs_pkg.sv =====
// Package for the output blink sequencer: codes, state types and reset constants.
package obs_pkg;

  localparam int unsigned LevelW     = 8;
  localparam int unsigned PeriodW    = 16;
  localparam int unsigned OpW        = 3;
  localparam int unsigned TimeBitsDef = 16;
  localparam int unsigned InDataW    = 48;
  localparam int unsigned OutDataW   = 16;

  localparam logic [LevelW-1:0] OnValueRst = 8'd255;

  typedef enum logic [OpW-1:0] {
    OP_TICK  = 3'd0,
    OP_ON    = 3'd1,
    OP_OFF   = 3'd2,
    OP_VALUE = 3'd3,
    OP_BLINK = 3'd4,
    OP_PAUSE = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    MODE_OFF   = 3'd0,
    MODE_ON    = 3'd1,
    MODE_VALUE = 3'd2,
    MODE_BLINK = 3'd3,
    MODE_PAUSE = 3'd4
  } mode_e;

  typedef struct packed {
    logic [OpW-1:0]     operation;
    logic [LevelW-1:0]  level;
    logic [LevelW-1:0]  pulse_target;
    logic [PeriodW-1:0] blink_period;
    logic [PeriodW-1:0] pause_period;
  } item_t;

  // Control part of the state; timers live apart since their width is a parameter.
  typedef struct packed {
    mode_e             mode;
    logic [LevelW-1:0] driven;
    logic [LevelW-1:0] reported;
    logic [LevelW-1:0] wanted;
    logic [LevelW-1:0] done;
  } ctl_t;

  localparam ctl_t CtlRst = '{
    mode:     MODE_OFF,
    driven:   '0,
    reported: '0,
    wanted:   '0,
    done:     '0
  };

endpackage

// ===== hw/rtl/obs_step.sv =====
// Next-state and result logic for one item of the output blink sequencer.
module obs_step #(
  parameter int unsigned TIME_BITS = obs_pkg::TimeBitsDef
) (
  input  obs_pkg::item_t                   item_i,
  input  logic [obs_pkg::LevelW-1:0]       on_level_i,
  input  obs_pkg::ctl_t                    ctl_i,
  input  logic [TIME_BITS-1:0]             tog_int_i,
  input  logic [TIME_BITS-1:0]             pau_int_i,
  input  logic [TIME_BITS-1:0]             tog_ela_i,
  input  logic [TIME_BITS-1:0]             pau_ela_i,
  output obs_pkg::ctl_t                    ctl_o,
  output logic [TIME_BITS-1:0]             tog_int_o,
  output logic [TIME_BITS-1:0]             pau_int_o,
  output logic [TIME_BITS-1:0]             tog_ela_o,
  output logic [TIME_BITS-1:0]             pau_ela_o,
  output logic                             changed_o
);
  import obs_pkg::*;

  localparam int unsigned ExtW = (TIME_BITS > PeriodW) ? TIME_BITS : PeriodW;

  logic [ExtW-1:0]      bper_ext, pper_ext;
  logic [TIME_BITS-1:0] bper, pper;
  logic                 same_blink, same_pause;

  assign bper_ext = ExtW'(item_i.blink_period);
  assign pper_ext = ExtW'(item_i.pause_period);
  assign bper     = bper_ext[TIME_BITS-1:0];
  assign pper     = pper_ext[TIME_BITS-1:0];

  assign same_blink = (ctl_i.mode == MODE_BLINK) && (ctl_i.wanted == item_i.pulse_target)
                      && (tog_int_i == bper);
  assign same_pause = (ctl_i.mode == MODE_PAUSE) && (ctl_i.wanted == item_i.pulse_target)
                      && (tog_int_i == bper) && (pau_int_i == pper);

  always_comb begin
    logic [TIME_BITS-1:0] te, pe;
    logic                 busy;
    ctl_o     = ctl_i;
    tog_int_o = tog_int_i;
    pau_int_o = pau_int_i;
    tog_ela_o = tog_ela_i;
    pau_ela_o = pau_ela_i;
    changed_o = 1'b0;
    te   = (&tog_ela_i) ? tog_ela_i : tog_ela_i + 1'b1;
    pe   = (&pau_ela_i) ? pau_ela_i : pau_ela_i + 1'b1;
    busy = ctl_i.done < ctl_i.wanted;

    case (item_i.operation)
      OP_TICK: begin
        tog_ela_o = te;
        pau_ela_o = pe;
        case (ctl_i.mode)
          MODE_OFF: ctl_o.driven = '0;
          MODE_ON:  ctl_o.driven = on_level_i;
          MODE_BLINK: begin
            if (te >= tog_int_i) begin
              if (busy) begin
                if (ctl_i.driven == '0) begin
                  ctl_o.driven = on_level_i;
                  ctl_o.done   = ctl_i.done + 1'b1;
                end else begin
                  ctl_o.driven = '0;
                end
                tog_ela_o = '0;
              end else begin
                // group finished: park low and forget the request
                ctl_o.driven = '0;
                ctl_o.done   = '0;
                ctl_o.wanted = '0;
              end
            end
          end
          MODE_PAUSE: begin
            if ((pe >= pau_int_i) && (te >= tog_int_i)) begin
              if (busy) begin
                if (ctl_i.driven == '0) begin
                  ctl_o.driven = on_level_i;
                  ctl_o.done   = ctl_i.done + 1'b1;
                end else begin
                  ctl_o.driven = '0;
                end
              end else begin
                ctl_o.driven = '0;
                ctl_o.done   = '0;
                pau_ela_o    = '0;
              end
              tog_ela_o = '0;
            end
          end
          default: ;
        endcase
        changed_o      = ctl_o.driven != ctl_i.reported;
        ctl_o.reported = ctl_o.driven;
      end
      OP_ON:  ctl_o.mode = MODE_ON;
      OP_OFF: ctl_o.mode = MODE_OFF;
      OP_VALUE: begin
        ctl_o.driven = item_i.level;
        ctl_o.mode   = MODE_VALUE;
      end
      OP_BLINK: begin
        if (!same_blink) begin
          ctl_o.wanted = item_i.pulse_target;
          ctl_o.done   = '0;
          tog_int_o    = bper;
          tog_ela_o    = '1;
        end
        ctl_o.mode = MODE_BLINK;
      end
      OP_PAUSE: begin
        if (!same_pause) begin
          ctl_o.wanted = item_i.pulse_target;
          ctl_o.done   = '0;
          tog_int_o    = bper;
          tog_ela_o    = '1;
          pau_int_o    = pper;
          pau_ela_o    = '1;
        end
        ctl_o.mode = MODE_PAUSE;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/output_blink_sequencer.sv =====
// Top level of the output blink sequencer: handshakes, state and result registers.
//
//   channel   dir  content
//   s_axis    in   tuser: operation; tdata: level, pulse_target, blink_period, pause_period
//   m_axis    out  tdata: port_level, level_changed
//   cfg       in   cfg_data_i: on level
//
// One item per cycle while m_axis is not stalled: an accepted transaction is
// captured in the input register, then the step logic updates the state and
// loads the result register. Result valid is registered there, so the output
// transaction comes after the input register and the result register in turn.
// A stalled result register holds the input register; the input side keeps
// accepting as long as the input register drains or is empty.
// Reset clears all state, the on level returns to 255.
module output_blink_sequencer #(
  parameter int unsigned TIME_BITS = obs_pkg::TimeBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] level, [15:8] pulse_target, [31:16] blink_period, [47:32] pause_period
  input  logic [obs_pkg::InDataW-1:0]    s_axis_tdata,
  // [2:0] operation
  input  logic [obs_pkg::OpW-1:0]        s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] port_level, [8] level_changed, [15:9] zero
  output logic [obs_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [obs_pkg::LevelW-1:0]     cfg_data_i
);
  import obs_pkg::*;

  logic                 in_valid_q;
  item_t                item_q;
  logic                 advance;

  logic [LevelW-1:0]    on_level_q;
  ctl_t                 ctl_q, ctl_d;
  logic [TIME_BITS-1:0] tog_int_q, tog_int_d, pau_int_q, pau_int_d;
  logic [TIME_BITS-1:0] tog_ela_q, tog_ela_d, pau_ela_q, pau_ela_d;
  logic                 changed_d;

  logic                 out_valid_q;
  logic [LevelW-1:0]    out_level_q;
  logic                 out_changed_q;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.operation    <= s_axis_tuser;
      item_q.level        <= s_axis_tdata[7:0];
      item_q.pulse_target <= s_axis_tdata[15:8];
      item_q.blink_period <= s_axis_tdata[31:16];
      item_q.pause_period <= s_axis_tdata[47:32];
    end
  end

  obs_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .item_i    (item_q),
    .on_level_i(on_level_q),
    .ctl_i     (ctl_q),
    .tog_int_i (tog_int_q),
    .pau_int_i (pau_int_q),
    .tog_ela_i (tog_ela_q),
    .pau_ela_i (pau_ela_q),
    .ctl_o     (ctl_d),
    .tog_int_o (tog_int_d),
    .pau_int_o (pau_int_d),
    .tog_ela_o (tog_ela_d),
    .pau_ela_o (pau_ela_d),
    .changed_o (changed_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_level_q <= OnValueRst;
    end else if (cfg_valid_i) begin
      on_level_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q     <= CtlRst;
      tog_int_q <= '0;
      pau_int_q <= '0;
      tog_ela_q <= '0;
      pau_ela_q <= '0;
    end else if (advance) begin
      ctl_q     <= ctl_d;
      tog_int_q <= tog_int_d;
      pau_int_q <= pau_int_d;
      tog_ela_q <= tog_ela_d;
      pau_ela_q <= pau_ela_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_level_q   <= ctl_d.driven;
      out_changed_q <= changed_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - LevelW - 1)'(0), out_changed_q, out_level_q};

endmodule
